@@ sv/srf_pkg.sv @@
// shared types, constants and float helpers for the segment reduce block
package srf_pkg;

  typedef enum logic [2:0] {
    MODE_SUM  = 3'd0,
    MODE_MEAN = 3'd1,
    MODE_MAX  = 3'd2,
    MODE_MIN  = 3'd3,
    MODE_PROD = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    REG_MODE  = 2'd0,
    REG_GIVEN = 2'd1,
    REG_INIT  = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COMB,
    ST_LZ,
    ST_RND,
    ST_FIN,
    ST_DPREP,
    ST_DIV,
    ST_OUT
  } bstate_t;

  localparam logic [31:0] QNAN_BITS    = 32'h7FC00000;
  localparam logic [31:0] POS_INF_BITS = 32'h7F800000;
  localparam logic [31:0] NEG_INF_BITS = 32'hFF800000;
  localparam logic [31:0] ONE_BITS     = 32'h3F800000;
  localparam logic [16:0] MAX_SEG_LEN  = 17'h10000;
  localparam int          DIV_BITS     = 43;

  typedef struct packed {
    logic [31:0] value;
    logic        carries;
    logic        closes;
    mode_t       mode;
    logic        given;
    logic [31:0] init;
  } job_t;

  function automatic logic is_nan(input logic [31:0] b);
    return b[30:0] > POS_INF_BITS[30:0];
  endfunction

  function automatic logic is_inf(input logic [31:0] b);
    return b[30:0] == POS_INF_BITS[30:0];
  endfunction

  function automatic logic is_zero(input logic [31:0] b);
    return b[30:0] == 31'd0;
  endfunction

  function automatic logic [31:0] canon(input logic [31:0] b);
    return is_nan(b) ? QNAN_BITS : b;
  endfunction

  function automatic logic [31:0] start_value(input mode_t m, input logic given,
                                              input logic [31:0] init);
    logic [31:0] r;
    if (given) begin
      r = init;
    end else begin
      case (m)
        MODE_MAX:  r = NEG_INF_BITS;
        MODE_MIN:  r = POS_INF_BITS;
        MODE_PROD: r = ONE_BITS;
        default:   r = 32'd0;
      endcase
    end
    return r;
  endfunction

  // a < b as ordered float compare
  function automatic logic flt(input logic [31:0] a, input logic [31:0] b);
    logic r;
    if (is_nan(a) || is_nan(b)) begin
      r = 1'b0;
    end else if (is_zero(a) && is_zero(b)) begin
      r = 1'b0;
    end else if (a[31] != b[31]) begin
      r = a[31];
    end else if (!a[31]) begin
      r = a[30:0] < b[30:0];
    end else begin
      r = a[30:0] > b[30:0];
    end
    return r;
  endfunction

  function automatic logic [5:0] lzc48(input logic [47:0] m);
    logic [5:0] r;
    r = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (m[i]) begin
        r = 6'(47 - i);
      end
    end
    return r;
  endfunction

  function automatic logic [4:0] lzc24(input logic [23:0] m);
    logic [4:0] r;
    r = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (m[i]) begin
        r = 5'(23 - i);
      end
    end
    return r;
  endfunction

  // e is the biased exponent of bit 25 of m, m normalized and nonzero
  function automatic logic [31:0] round_pack(input logic s, input logic signed [10:0] e,
                                             input logic [25:0] m, input logic st);
    logic signed [10:0] sh;
    logic [25:0]        mm;
    logic [25:0]        mask;
    logic               stk;
    logic [7:0]         ef;
    logic               inc;
    logic [30:0]        mag;
    sh = 11'sd1 - e;
    mm = m;
    stk = st;
    ef = e[7:0];
    mask = 26'd0;
    if (e >= 11'sd255) begin
      return {s, POS_INF_BITS[30:0]};
    end
    if (e < 11'sd1) begin
      ef = 8'd0;
      if (sh > 11'sd25) begin
        mm = 26'd0;
        stk = st | (|m);
      end else begin
        mask = (26'd1 << sh[4:0]) - 26'd1;
        mm = m >> sh[4:0];
        stk = st | (|(m & mask));
      end
    end
    inc = mm[1] & (mm[0] | stk | mm[2]);
    mag = {ef, mm[24:2]} + {30'd0, inc};
    return {s, mag};
  endfunction

endpackage

@@ sv/srf_if.sv @@
// request channels for input items and segment results
interface srf_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic        carries_value;
  logic        closes_segment;
  modport source (output valid, value, carries_value, closes_segment, input ready);
  modport sink (input valid, value, carries_value, closes_segment, output ready);
endinterface

interface srf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] segment_result;
  modport source (output valid, segment_result, input ready);
  modport sink (input valid, segment_result, output ready);
endinterface

@@ sv/srf_front.sv @@
// front end: accepts requests, drops idle ones, tags them with the configuration
module srf_front (
  srf_in_if.sink        items,
  input  logic [2:0]    cfg_mode,
  input  logic          cfg_given,
  input  logic [31:0]   cfg_init,
  input  logic          q_full,
  output logic          q_push,
  output srf_pkg::job_t q_job
);
  import srf_pkg::*;

  mode_t mode_dec;

  always_comb begin
    case (cfg_mode)
      MODE_MEAN: mode_dec = MODE_MEAN;
      MODE_MAX:  mode_dec = MODE_MAX;
      MODE_MIN:  mode_dec = MODE_MIN;
      MODE_PROD: mode_dec = MODE_PROD;
      default:   mode_dec = MODE_SUM;
    endcase
  end

  assign items.ready = !q_full;
  assign q_push = items.valid && !q_full && (items.carries_value || items.closes_segment);

  always_comb begin
    q_job.value   = items.value;
    q_job.carries = items.carries_value;
    q_job.closes  = items.closes_segment;
    q_job.mode    = mode_dec;
    q_job.given   = cfg_given;
    q_job.init    = cfg_init;
  end

endmodule

@@ sv/srf_fifo.sv @@
// four entry queue between front and back
module srf_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  srf_pkg::job_t push_job,
  input  logic          pop,
  output srf_pkg::job_t head,
  output logic          not_empty,
  output logic          full
);
  import srf_pkg::*;

  job_t       slots [4];
  logic [1:0] wptr;
  logic [1:0] rptr;
  logic [2:0] fill;

  assign full      = fill == 3'd4;
  assign not_empty = fill != 3'd0;
  assign head      = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 2'd0;
      rptr <= 2'd0;
      fill <= 3'd0;
    end else begin
      if (push) begin
        wptr <= wptr + 2'd1;
      end
      if (pop) begin
        rptr <= rptr + 2'd1;
      end
      if (push && !pop) begin
        fill <= fill + 3'd1;
      end else if (pop && !push) begin
        fill <= fill - 3'd1;
      end
    end
  end

endmodule

@@ sv/srf_back.sv @@
// back end: float add, multiply, compare, mean divide and result register
module srf_back (
  input  logic          clk,
  input  logic          rst,
  input  srf_pkg::job_t job,
  input  logic          job_valid,
  output logic          job_pop,
  srf_out_if.source     results
);
  import srf_pkg::*;

  bstate_t            state;
  bstate_t            state_next;
  job_t               cur;
  logic [31:0]        acc;
  logic [16:0]        count;
  logic               nsign;
  logic signed [10:0] nexp;
  logic [47:0]        nm;
  logic               nst;
  logic [5:0]         lz;
  logic               div_phase;
  logic [31:0]        res;
  logic [16:0]        dvsr;
  logic [16:0]        rem;
  logic [42:0]        dd;
  logic [5:0]         dcnt;
  logic signed [10:0] dexp;
  logic               dsign;
  logic               ov;
  logic [31:0]        odata;
  logic               load_out;

  logic [31:0]        a_cur;
  logic               minmax;
  logic [31:0]        mm_val;
  logic               spec;
  logic [31:0]        spec_val;
  logic               raw_sign;
  logic signed [10:0] raw_exp;
  logic [47:0]        raw_m;
  logic [7:0]         ea;
  logic [7:0]         ev;
  logic [23:0]        ma;
  logic [23:0]        mv;
  logic [31:0]        big;
  logic [31:0]        sml;
  logic [7:0]         eb;
  logic [7:0]         es;
  logic [23:0]        mb;
  logic [23:0]        ms;
  logic [7:0]         dsh;
  logic [26:0]        sm_full;
  logic [26:0]        sm27;
  logic [26:0]        sm_mask;
  logic               sub;
  logic [27:0]        sum28;
  logic [47:0]        prod;
  logic [47:0]        nrm;
  logic signed [10:0] rnd_exp;
  logic [31:0]        rnd_val;
  logic               fin_div;
  logic [31:0]        fin_res;
  logic [4:0]         plz;
  logic [23:0]        pm;
  logic [7:0]         pe;
  logic [17:0]        rem_sh;
  logic               qbit;
  logic [16:0]        rem_new;
  logic [42:0]        dd_new;
  logic [16:0]        count_inc;

  assign a_cur = (count == 17'd0) ? canon(start_value(cur.mode, cur.given, cur.init)) : acc;
  assign minmax = cur.mode inside {MODE_MAX, MODE_MIN};
  assign count_inc = (count < MAX_SEG_LEN) ? count + 17'd1 : count;

  always_comb begin
    ea = (a_cur[30:23] == 8'd0) ? 8'd1 : a_cur[30:23];
    ev = (cur.value[30:23] == 8'd0) ? 8'd1 : cur.value[30:23];
    ma = {|a_cur[30:23], a_cur[22:0]};
    mv = {|cur.value[30:23], cur.value[22:0]};

    if (is_nan(cur.value)) begin
      mm_val = QNAN_BITS;
    end else if (cur.mode == MODE_MAX) begin
      mm_val = flt(a_cur, cur.value) ? cur.value : a_cur;
    end else begin
      mm_val = flt(cur.value, a_cur) ? cur.value : a_cur;
    end

    if (a_cur[30:0] >= cur.value[30:0]) begin
      big = a_cur;
      sml = cur.value;
      eb = ea;
      es = ev;
      mb = ma;
      ms = mv;
    end else begin
      big = cur.value;
      sml = a_cur;
      eb = ev;
      es = ea;
      mb = mv;
      ms = ma;
    end
    dsh = eb - es;
    sm_full = {ms, 3'd0};
    sm_mask = 27'd0;
    if (dsh >= 8'd27) begin
      sm27 = {26'd0, |ms};
    end else begin
      sm_mask = (27'd1 << dsh[4:0]) - 27'd1;
      sm27 = (sm_full >> dsh[4:0]) | {26'd0, |(sm_full & sm_mask)};
    end
    sub = big[31] ^ sml[31];
    sum28 = sub ? ({1'b0, mb, 3'd0} - {1'b0, sm27}) : ({1'b0, mb, 3'd0} + {1'b0, sm27});
    prod = ma * mv;

    spec = 1'b0;
    spec_val = QNAN_BITS;
    if (cur.mode == MODE_PROD) begin
      raw_sign = a_cur[31] ^ cur.value[31];
      raw_exp = $signed({3'd0, ea}) + $signed({3'd0, ev}) - 11'sd126;
      raw_m = prod;
      if (is_nan(a_cur) || is_nan(cur.value)) begin
        spec = 1'b1;
      end else if ((is_inf(a_cur) && is_zero(cur.value)) ||
                   (is_zero(a_cur) && is_inf(cur.value))) begin
        spec = 1'b1;
      end else if (is_inf(a_cur) || is_inf(cur.value)) begin
        spec = 1'b1;
        spec_val = {raw_sign, POS_INF_BITS[30:0]};
      end else if (is_zero(a_cur) || is_zero(cur.value)) begin
        spec = 1'b1;
        spec_val = {raw_sign, 31'd0};
      end
    end else begin
      raw_sign = (sum28 == 28'd0) ? (sub ? 1'b0 : big[31]) : big[31];
      raw_exp = $signed({3'd0, eb}) + 11'sd1;
      raw_m = {sum28, 20'd0};
      if (is_nan(a_cur) || is_nan(cur.value)) begin
        spec = 1'b1;
      end else if (is_inf(a_cur) && is_inf(cur.value) && sub) begin
        spec = 1'b1;
      end else if (is_inf(a_cur)) begin
        spec = 1'b1;
        spec_val = a_cur;
      end else if (is_inf(cur.value)) begin
        spec = 1'b1;
        spec_val = cur.value;
      end
    end

    nrm = nm << lz;
    rnd_exp = nexp - $signed({5'd0, lz});
    rnd_val = (nm == 48'd0) ? {nsign, 31'd0} :
              round_pack(nsign, rnd_exp, nrm[47:22], nst | (|nrm[21:0]));

    fin_div = 1'b0;
    fin_res = canon(a_cur);
    if (cur.mode == MODE_MEAN) begin
      if (count == 17'd0 && !cur.given) begin
        fin_res = QNAN_BITS;
      end else if (count != 17'd0 && !is_nan(a_cur) && !is_inf(a_cur) && !is_zero(a_cur)) begin
        fin_div = 1'b1;
      end
    end

    pm = {|acc[30:23], acc[22:0]};
    pe = (acc[30:23] == 8'd0) ? 8'd1 : acc[30:23];
    plz = lzc24(pm);

    rem_sh = {rem, dd[42]};
    qbit = rem_sh >= {1'b0, dvsr};
    rem_new = qbit ? 17'(rem_sh - {1'b0, dvsr}) : rem_sh[16:0];
    dd_new = {dd[41:0], qbit};
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (job_valid) begin
          state_next = ST_COMB;
        end
      end
      ST_COMB: begin
        if (!cur.carries) begin
          state_next = ST_FIN;
        end else if (minmax || spec) begin
          state_next = cur.closes ? ST_FIN : ST_IDLE;
        end else begin
          state_next = ST_LZ;
        end
      end
      ST_LZ: state_next = ST_RND;
      ST_RND: begin
        if (div_phase) begin
          state_next = ST_OUT;
        end else begin
          state_next = cur.closes ? ST_FIN : ST_IDLE;
        end
      end
      ST_FIN: state_next = fin_div ? ST_DPREP : ST_OUT;
      ST_DPREP: state_next = ST_DIV;
      ST_DIV: begin
        if (dcnt == 6'd1) begin
          state_next = ST_LZ;
        end
      end
      ST_OUT: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    job_pop = (state == ST_IDLE) && job_valid;
    load_out = (state == ST_OUT) && (!ov || results.ready);
    results.valid = ov;
    results.segment_result = odata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= 17'd0;
      acc <= 32'd0;
      ov <= 1'b0;
      div_phase <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        ov <= 1'b1;
      end else if (ov && results.ready) begin
        ov <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          div_phase <= 1'b0;
        end
        ST_COMB: begin
          if (cur.carries) begin
            count <= count_inc;
            if (minmax) begin
              acc <= mm_val;
            end else if (spec) begin
              acc <= spec_val;
            end
          end
        end
        ST_RND: begin
          if (!div_phase) begin
            acc <= rnd_val;
          end
        end
        ST_FIN: begin
          acc <= a_cur;
          count <= 17'd0;
        end
        ST_DIV: begin
          if (dcnt == 6'd1) begin
            div_phase <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      odata <= res;
    end
    case (state)
      ST_IDLE: begin
        if (job_valid) begin
          cur <= job;
        end
      end
      ST_COMB: begin
        nsign <= raw_sign;
        nexp <= raw_exp;
        nm <= raw_m;
        nst <= 1'b0;
      end
      ST_LZ: lz <= lzc48(nm);
      ST_RND: res <= rnd_val;
      ST_FIN: begin
        res <= fin_res;
        dvsr <= count;
      end
      ST_DPREP: begin
        dd <= {pm << plz, 19'd0};
        dexp <= $signed({3'd0, pe}) - $signed({6'd0, plz});
        dsign <= acc[31];
        rem <= 17'd0;
        dcnt <= 6'(DIV_BITS);
      end
      ST_DIV: begin
        dd <= dd_new;
        rem <= rem_new;
        dcnt <= dcnt - 6'd1;
        if (dcnt == 6'd1) begin
          nm <= {dd_new, 5'd0};
          nexp <= dexp;
          nsign <= dsign;
          nst <= rem_new != 17'd0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ sv/segment_reduce_forward_core.sv @@
// top level: configuration registers, front end, queue and back end
//
//  channel   | dir | handshake           | payload
//  items     | in  | valid / ready       | value, carries_value, closes_segment
//  results   | out | valid / ready       | segment_result
//  apb       | in  | psel/penable/pready | paddr, pwdata, prdata
//
// add or product element: dequeue, align or multiply, count, round
// max or min element: dequeue, compare; closing a segment adds the finish and output steps
// mean close adds the one bit per cycle count divider
// the 4 entry queue takes requests while the back end works or the result waits
// rst is synchronous and clears queue, state, count and the result valid flag
module segment_reduce_forward_core (
  input  logic             clk,
  input  logic             rst,
  srf_in_if.sink           items,
  srf_out_if.source        results,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import srf_pkg::*;

  logic [2:0]  reduce_mode;
  logic        initial_given;
  logic [31:0] start_bits;
  logic        q_full;
  logic        q_push;
  job_t        q_job;
  job_t        q_head;
  logic        q_not_empty;
  logic        q_pop;
  reg_idx_t    idx;

  assign pready = 1'b1;
  assign idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      reduce_mode <= 3'd0;
      initial_given <= 1'b0;
      start_bits <= 32'd0;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_MODE:  reduce_mode <= pwdata[2:0];
        REG_GIVEN: initial_given <= pwdata[0];
        REG_INIT:  start_bits <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MODE:  prdata = {29'd0, reduce_mode};
      REG_GIVEN: prdata = {31'd0, initial_given};
      REG_INIT:  prdata = start_bits;
      default:   prdata = 32'd0;
    endcase
  end

  srf_front u_front (
    .items     (items),
    .cfg_mode  (reduce_mode),
    .cfg_given (initial_given),
    .cfg_init  (start_bits),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_job)
  );

  srf_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_job  (q_job),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  srf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (q_head),
    .job_valid (q_not_empty),
    .job_pop   (q_pop),
    .results   (results)
  );

endmodule

@@ sv/srf_checker.sv @@
// port level checks for the segment reduce block, bound to the top level
module srf_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_data,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [3:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata
);
  import srf_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result present right after reset");

  a_mode_readback: assert property (@(posedge clk) disable iff (rst)
    ($past(psel && penable && pwrite) && !$past(rst) &&
     $past(paddr[3:2]) == REG_MODE && psel && !pwrite && paddr[3:2] == REG_MODE)
    |-> prdata[2:0] == $past(pwdata[2:0]))
    else $error("mode register readback mismatch");

endmodule

bind segment_reduce_forward_core srf_checker u_srf_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_data  (results.segment_result),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);

@@ tb/sv/segment_reduce_forward_core_tb.sv @@
// testbench for segment_reduce_forward_core with a float predictor
`timescale 1ns / 1ps
module segment_reduce_forward_core_tb;
  import srf_pkg::*;

  localparam int MAX_LEN    = 65536;
  localparam int BURST_LEN  = 40;
  localparam int DRAIN_WAIT = 120;
  localparam int STALL_CAP  = 20000;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  srf_in_if  in_ch ();
  srf_out_if out_ch ();

  segment_reduce_forward_core uut (
    .clk(clk), .rst(rst), .items(in_ch), .results(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  logic [2:0]  cfg_mode;
  logic        cfg_given;
  logic [31:0] cfg_init;
  logic [31:0] acc_bits;
  int          seg_count;
  logic [31:0] expected_sums[$];
  int          mismatches;
  int          idle_cycles;
  bit          jitter_on;
  int          stall_left;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // float conversions through double precision
  function automatic real bits_to_real(input logic [31:0] b);
    logic [63:0] d;
    int          ex;
    logic [23:0] mm;
    if (b[30:23] == 8'hFF) begin
      d = {b[31], 11'h7FF, b[22:0], 29'd0};
    end else if (b[30:0] == 31'd0) begin
      d = {b[31], 63'd0};
    end else begin
      ex = (b[30:23] == 8'd0) ? 1 : int'(b[30:23]);
      mm = {(b[30:23] != 8'd0), b[22:0]};
      while (!mm[23]) begin
        mm = mm << 1;
        ex = ex - 1;
      end
      d = {b[31], 11'(ex - 127 + 1023), mm[22:0], 29'd0};
    end
    return $bitstoreal(d);
  endfunction

  function automatic logic [31:0] real_to_bits(input real r);
    logic [63:0] d;
    logic [63:0] sig;
    logic [63:0] kept;
    logic [31:0] mag;
    int          ef;
    int          sh;
    logic        guard;
    logic        sticky;
    d = $realtobits(r);
    if (d[62:52] == 11'h7FF) begin
      return (d[51:0] != 0) ? QNAN_BITS : {d[63], POS_INF_BITS[30:0]};
    end
    if (d[62:0] == 63'd0) begin
      return {d[63], 31'd0};
    end
    sig = {11'd0, 1'b1, d[51:0]};
    ef = int'(d[62:52]) - 1023 + 127;
    sh = (ef >= 1) ? 29 : 29 + (1 - ef);
    if (sh > 60) begin
      return {d[63], 31'd0};
    end
    kept = sig >> sh;
    guard = sig[sh - 1];
    sticky = (sig & ((64'd1 << (sh - 1)) - 64'd1)) != 64'd0;
    kept = kept + 64'(guard & (sticky | kept[0]));
    mag = ((ef >= 1) ? 32'(ef - 1) << 23 : 32'd0) + kept[31:0];
    if (mag >= {1'b0, POS_INF_BITS[30:0]}) begin
      mag = {1'b0, POS_INF_BITS[30:0]};
    end
    return {d[63], mag[30:0]};
  endfunction

  function automatic bit nan_bits(input logic [31:0] b);
    return b[30:0] > POS_INF_BITS[30:0];
  endfunction

  function automatic logic [31:0] quiet(input logic [31:0] b);
    return nan_bits(b) ? QNAN_BITS : b;
  endfunction

  function automatic bit less_than(input logic [31:0] a, input logic [31:0] b);
    if (nan_bits(a) || nan_bits(b)) begin
      return 1'b0;
    end
    return bits_to_real(a) < bits_to_real(b);
  endfunction

  function automatic logic [31:0] seed_value();
    if (cfg_given) begin
      return cfg_init;
    end
    case (cfg_mode)
      MODE_MAX:  return NEG_INF_BITS;
      MODE_MIN:  return POS_INF_BITS;
      MODE_PROD: return ONE_BITS;
      default:   return 32'd0;
    endcase
  endfunction

  function automatic logic [31:0] fold_element(input logic [31:0] a, input logic [31:0] v);
    case (cfg_mode)
      MODE_MAX: begin
        if (nan_bits(v)) return QNAN_BITS;
        return less_than(a, v) ? v : a;
      end
      MODE_MIN: begin
        if (nan_bits(v)) return QNAN_BITS;
        return less_than(v, a) ? v : a;
      end
      MODE_PROD: return quiet(real_to_bits(bits_to_real(a) * bits_to_real(v)));
      default:   return quiet(real_to_bits(bits_to_real(a) + bits_to_real(v)));
    endcase
  endfunction

  // advance the segment state for one accepted request
  task automatic reduce_step(input logic [31:0] v, input logic c, input logic cl);
    logic [31:0] res;
    if (c) begin
      if (seg_count == 0) acc_bits = quiet(seed_value());
      acc_bits = fold_element(acc_bits, v);
      if (seg_count < MAX_LEN) seg_count++;
    end
    if (cl) begin
      if (seg_count == 0) acc_bits = quiet(seed_value());
      res = acc_bits;
      if (cfg_mode == MODE_MEAN) begin
        if (seg_count == 0 && !cfg_given) begin
          res = QNAN_BITS;
        end else if (seg_count > 0 && !nan_bits(res)) begin
          res = real_to_bits(bits_to_real(res) / real'(seg_count));
        end
      end
      expected_sums.push_back(quiet(res));
      seg_count = 0;
    end
  endtask

  task automatic send_item(input logic [31:0] v, input logic c, input logic cl);
    if (jitter_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_ch.carries_value <= c;
    in_ch.closes_segment <= cl;
    do @(posedge clk); while (!in_ch.ready);
    reduce_step(v, c, cl);
  endtask

  task automatic stop_sending();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    stop_sending();
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic reg_write(input reg_idx_t idx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 4'(idx) << 2;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MODE:  cfg_mode = data[2:0];
      REG_GIVEN: cfg_given = data[0];
      default:   cfg_init = data;
    endcase
  endtask

  task automatic set_config(input logic [2:0] m, input logic g, input logic [31:0] iv);
    wait_drained();
    reg_write(REG_MODE, 32'(m));
    reg_write(REG_GIVEN, 32'(g));
    reg_write(REG_INIT, iv);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 11))
      0: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'd0};
      1: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, POS_INF_BITS[30:0]};
      2: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'hFF, 23'($urandom_range(1, 32'h7FFFFF))};
      3: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'h00, 23'($urandom())};
      4: return $urandom();
      5: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'hFE, 23'($urandom())};
      default: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'($urandom_range(110, 145)),
                       23'($urandom())};
    endcase
  endfunction

  task automatic send_segment(input int len);
    for (int i = 0; i < len; i++) send_item(pick_value(), 1'b1, i == len - 1);
    if (len == 0) send_item(pick_value(), 1'b0, 1'b1);
  endtask

  task automatic test_modes();
    logic [2:0] m;
    for (int k = 0; k < 5; k++) begin
      m = 3'(k);
      set_config(m, 1'b0, 32'd0);
      send_item(32'h3F800000, 1'b1, 1'b0);
      send_item(32'hC0400000, 1'b1, 1'b0);
      send_item(32'h00000001, 1'b1, 1'b1);
      send_item(32'h7F7FFFFF, 1'b1, 1'b0);
      send_item(32'h7F7FFFFF, 1'b1, 1'b1);
    end
  endtask

  task automatic test_nan_and_empty();
    set_config(MODE_MAX, 1'b0, 32'd0);
    send_item(32'h40000000, 1'b1, 1'b0);
    send_item(32'hFF800001, 1'b1, 1'b0);
    send_item(32'h7F800000, 1'b1, 1'b1);
    send_item(32'd0, 1'b0, 1'b1);
    set_config(MODE_MIN, 1'b1, 32'h7FC00001);
    send_item(32'h80000000, 1'b1, 1'b1);
    send_item(32'd0, 1'b0, 1'b1);
    set_config(MODE_MEAN, 1'b0, 32'd0);
    send_item(32'd0, 1'b0, 1'b1);
    send_item(32'd0, 1'b0, 1'b0);
    send_item(32'h7F800000, 1'b1, 1'b0);
    send_item(32'hFF800000, 1'b1, 1'b1);
    set_config(MODE_MEAN, 1'b1, 32'hBF800000);
    send_item(32'd0, 1'b0, 1'b1);
    send_item(32'h40400000, 1'b1, 1'b1);
    set_config(3'd7, 1'b1, 32'hFFFFFFFF);
    send_item(32'h3F800000, 1'b1, 1'b1);
  endtask

  task automatic test_mode_switch();
    set_config(MODE_SUM, 1'b0, 32'd0);
    send_item(32'h40A00000, 1'b1, 1'b0);
    set_config(MODE_PROD, 1'b0, 32'd0);
    send_item(32'h40000000, 1'b1, 1'b0);
    set_config(MODE_MEAN, 1'b0, 32'd0);
    send_item(32'h3F800000, 1'b1, 1'b1);
  endtask

  task automatic test_random();
    int sent;
    for (int ph = 0; ph < 6; ph++) begin
      set_config(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                 ($urandom_range(0, 1)) ? pick_value() : 32'd0);
      sent = 0;
      while (sent < 90) begin
        if ($urandom_range(0, 9) == 0) begin
          send_item($urandom(), 1'b0, 1'b0);
        end else begin
          send_segment($urandom_range(0, 8));
          sent = sent + 5;
        end
        if (ph == 2 && sent >= 45 && sent < 50) begin
          stop_sending();
          while (expected_sums.size() != 0) @(posedge clk);
        end
      end
    end
  endtask

  task automatic test_back_to_back();
    jitter_on = 1'b0;
    set_config(MODE_MEAN, 1'b1, 32'h3F800000);
    for (int i = 0; i < BURST_LEN; i++) send_item(32'h3F000000, 1'b1, i == BURST_LEN - 1);
    send_item(32'h41200000, 1'b1, 1'b1);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (jitter_on && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= $urandom_range(0, 12);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_sums.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_ch.segment_result);
      end else begin
        want = expected_sums.pop_front();
        if (out_ch.segment_result !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("segment_result: expected %h actual %h", want, out_ch.segment_result);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_CAP) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 4'd0;
    pwdata = 32'd0;
    in_ch.valid = 1'b0;
    in_ch.value = 32'd0;
    in_ch.carries_value = 1'b0;
    in_ch.closes_segment = 1'b0;
    cfg_mode = MODE_SUM;
    cfg_given = 1'b0;
    cfg_init = 32'd0;
    acc_bits = 32'd0;
    seg_count = 0;
    mismatches = 0;
    jitter_on = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_modes();
    test_nan_and_empty();
    test_mode_switch();
    test_random();
    test_back_to_back();
    wait_drained();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

@@ sim.f @@
sv/srf_pkg.sv
sv/srf_if.sv
sv/srf_front.sv
sv/srf_fifo.sv
sv/srf_back.sv
sv/segment_reduce_forward_core.sv
sv/srf_checker.sv
tb/sv/segment_reduce_forward_core_tb.sv
